@@ rtl/core/prq_pkg.sv @@
// Shared types and constants for the priority ready-queue scheduler.
// No dependencies.
package prq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int LEN_W     = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W    = 8;
  localparam int DLY_W     = 16;
  localparam int ISR_W     = 8;
  localparam int SW_W      = 16;

  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_DELAY     = 3'd1;
  localparam logic [2:0] OP_START     = 3'd2;
  localparam logic [2:0] OP_IRQ_ENTER = 3'd3;
  localparam logic [2:0] OP_IRQ_EXIT  = 3'd4;

  localparam logic [1:0] DISP_NONE  = 2'd0;
  localparam logic [1:0] DISP_FIRST = 2'd1;
  localparam logic [1:0] DISP_UNRUN = 2'd2;
  localparam logic [1:0] DISP_SWAP  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [PRIO_W-1:0] priority_req;
    logic [DLY_W-1:0]  delay_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      dispatch;
    logic [3:0]      next_task;
    logic [SW_W-1:0] switch_count;
    logic [1:0]      status;
  } result_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
  } list_ctl_t;

  typedef struct packed {
    logic       latch;
    logic       create;
    logic       remove;
    logic       dins;
    logic       set_started;
    logic       isr_inc;
    logic       isr_dec;
    logic       sched;
    logic       set_status;
    logic [1:0] status_code;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       dly_zero;
    logic       full;
    logic       cur_valid;
    logic       started;
    logic       isr_zero;
    logic       isr_one;
    logic       rem_found;
  } dp_stat_t;

endpackage

@@ rtl/core/prq_list.sv @@
// Priority-sorted list of task slots held in a row of shift cells.
// Depends on prq_pkg.
module prq_list import prq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  list_ctl_t         ctl,
  output logic [LEN_W-1:0]  len,
  output logic [SLOT_W-1:0] head,
  output logic              rem_found,
  output logic [PRIO_W-1:0] rem_prio
);

  logic [SLOT_W-1:0] slot_q [MAX_TASKS];
  logic [PRIO_W-1:0] prio_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] place, match, after;
  logic [PRIO_W-1:0] match_prio;

  always_comb begin
    match_prio = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      place[i] = (LEN_W'(i) >= len) || (prio_q[i] >= ctl.prio);
      match[i] = (LEN_W'(i) < len) && (slot_q[i] == ctl.slot);
      if (match[i]) begin
        match_prio = match_prio | prio_q[i];
      end
    end
    after[0] = match[0];
    for (int i = 1; i < MAX_TASKS; i++) begin
      after[i] = after[i-1] | match[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      rem_found <= 1'b0;
    end else begin
      if (ctl.ins && len < LEN_W'(MAX_TASKS)) begin
        len <= len + 1'b1;
      end
      if (ctl.rem) begin
        rem_found <= |match;
        if (|match) begin
          len <= len - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rem) begin
      rem_prio <= match_prio;
    end
    if (ctl.ins && len < LEN_W'(MAX_TASKS)) begin
      // open a gap at the first entry not more urgent than the new one
      if (place[0]) begin
        slot_q[0] <= ctl.slot;
        prio_q[0] <= ctl.prio;
      end
      for (int i = 1; i < MAX_TASKS; i++) begin
        if (place[i-1]) begin
          slot_q[i] <= slot_q[i-1];
          prio_q[i] <= prio_q[i-1];
        end else if (place[i]) begin
          slot_q[i] <= ctl.slot;
          prio_q[i] <= ctl.prio;
        end
      end
    end else if (ctl.rem) begin
      // close the gap behind the matching entry
      for (int i = 0; i < MAX_TASKS - 1; i++) begin
        if (after[i]) begin
          slot_q[i] <= slot_q[i+1];
          prio_q[i] <= prio_q[i+1];
        end
      end
    end
  end

  assign head = slot_q[0];

endmodule

@@ rtl/core/prq_datapath.sv @@
// Scheduler datapath: task state, ready and delayed lists, result register.
// Depends on prq_pkg and prq_list.
module prq_datapath import prq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cmd_t     cmd_in,
  input  dp_cmd_t  ctl,
  output dp_stat_t stat,
  output logic     result_valid,
  output result_t  result
);

  cmd_t              item_q;
  logic [LEN_W-1:0]  task_total;
  logic [SLOT_W-1:0] current_task;
  logic              current_valid;
  logic [ISR_W-1:0]  isr_depth;
  logic              started;
  logic [SW_W-1:0]   switch_total;
  logic [MAX_TASKS-1:0] has_run;
  logic [1:0]        dispatch_q;
  logic [1:0]        status_q;

  list_ctl_t         rdy_ctl, dly_ctl;
  logic [LEN_W-1:0]  rdy_len, dly_len;
  logic [SLOT_W-1:0] rdy_head, dly_head;
  logic              rdy_found, dly_found;
  logic [PRIO_W-1:0] rdy_prio, dly_prio;
  logic [SLOT_W-1:0] next_slot;

  always_comb begin
    rdy_ctl.ins  = ctl.create;
    rdy_ctl.rem  = ctl.remove;
    rdy_ctl.slot = ctl.create ? task_total[SLOT_W-1:0] : current_task;
    rdy_ctl.prio = item_q.priority_req;
    dly_ctl.ins  = ctl.dins;
    dly_ctl.rem  = 1'b0;
    dly_ctl.slot = current_task;
    dly_ctl.prio = rdy_prio;
  end

  prq_list u_ready (
    .clk(clk), .rst(rst), .ctl(rdy_ctl), .len(rdy_len), .head(rdy_head),
    .rem_found(rdy_found), .rem_prio(rdy_prio)
  );

  prq_list u_delayed (
    .clk(clk), .rst(rst), .ctl(dly_ctl), .len(dly_len), .head(dly_head),
    .rem_found(dly_found), .rem_prio(dly_prio)
  );

  always_comb begin
    stat.op        = item_q.opcode;
    stat.dly_zero  = (item_q.delay_count == '0);
    stat.full      = (task_total == LEN_W'(MAX_TASKS));
    stat.cur_valid = current_valid;
    stat.started   = started;
    stat.isr_zero  = (isr_depth == '0);
    stat.isr_one   = (isr_depth == ISR_W'(1));
    stat.rem_found = rdy_found;
    next_slot      = (rdy_len != '0) ? rdy_head : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_q <= cmd_in;
    end
    result <= '{dispatch: dispatch_q, next_task: 4'(next_slot),
                switch_count: switch_total, status: status_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_total    <= '0;
      current_task  <= '0;
      current_valid <= 1'b0;
      isr_depth     <= '0;
      started       <= 1'b0;
      switch_total  <= '0;
      has_run       <= '0;
      dispatch_q    <= DISP_NONE;
      status_q      <= ST_DONE;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= ctl.emit;
      if (ctl.latch) begin
        dispatch_q <= DISP_NONE;
        status_q   <= ST_DONE;
      end
      if (ctl.set_status) begin
        status_q <= ctl.status_code;
      end
      if (ctl.create) begin
        has_run[task_total[SLOT_W-1:0]] <= 1'b0;
        task_total <= task_total + 1'b1;
      end
      if (ctl.set_started) begin
        started <= 1'b1;
      end
      if (ctl.isr_inc && isr_depth != '1) begin
        isr_depth <= isr_depth + 1'b1;
      end
      if (ctl.isr_dec) begin
        isr_depth <= isr_depth - 1'b1;
      end
      if (ctl.sched && rdy_len != '0) begin
        if (!current_valid) begin
          switch_total  <= switch_total + 1'b1;
          current_task  <= rdy_head;
          current_valid <= 1'b1;
          dispatch_q    <= DISP_FIRST;
        end else if (current_task != rdy_head) begin
          switch_total          <= switch_total + 1'b1;
          dispatch_q            <= has_run[current_task] ? DISP_SWAP : DISP_UNRUN;
          has_run[current_task] <= 1'b1;
          current_task          <= rdy_head;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_bound: assert property (@(posedge clk) disable iff (rst)
    rdy_len <= task_total) else $error("ready list longer than task table");
  a_delay_bound: assert property (@(posedge clk) disable iff (rst)
    (LEN_W + 1)'(rdy_len) + (LEN_W + 1)'(dly_len) <= (LEN_W + 1)'(task_total))
    else $error("lists hold more tasks than created");
  a_switch_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.sched |=> $stable(switch_total)) else $error("switch count moved");
  a_cur_sticky: assert property (@(posedge clk) disable iff (rst)
    current_valid |=> current_valid) else $error("current task lost");
`endif

endmodule

@@ rtl/core/prq_ctrl.sv @@
// Scheduler controller: sequences each command through the datapath.
// Depends on prq_pkg.
module prq_ctrl import prq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl,
  output logic     busy
);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DELAY, S_SCHED, S_RESULT} state_t;
  state_t state, state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        ctl.latch = start;
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_RESULT;
        unique case (stat.op)
          OP_CREATE: begin
            if (stat.full) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_FULL;
            end else begin
              ctl.create = 1'b1;
              if (stat.started) state_next = S_SCHED;
            end
          end
          OP_DELAY: begin
            if (!stat.dly_zero) begin
              if (!stat.cur_valid) begin
                ctl.set_status  = 1'b1;
                ctl.status_code = ST_IGNORED;
              end else begin
                ctl.remove = 1'b1;
                state_next = S_DELAY;
              end
            end
          end
          OP_START: begin
            ctl.set_started = 1'b1;
            state_next      = S_SCHED;
          end
          OP_IRQ_ENTER: ctl.isr_inc = 1'b1;
          OP_IRQ_EXIT: begin
            if (stat.isr_zero) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_IGNORED;
            end else begin
              ctl.isr_dec = 1'b1;
              if (stat.isr_one && stat.cur_valid) state_next = S_SCHED;
            end
          end
          default: begin
            ctl.set_status  = 1'b1;
            ctl.status_code = ST_IGNORED;
          end
        endcase
      end
      S_DELAY: begin
        // park the removed task, or drop the command if it was not ready
        if (stat.rem_found) begin
          ctl.dins   = 1'b1;
          state_next = S_SCHED;
        end else begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_IGNORED;
          state_next      = S_RESULT;
        end
      end
      S_SCHED: begin
        ctl.sched  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> !ctl.emit) else $error("double result");
  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.latch |-> !busy) else $error("transfer while busy");
  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    ctl.sched |=> ctl.emit) else $error("schedule not followed by result");
`endif

endmodule

@@ rtl/core/priority_ready_queue_scheduler.sv @@
// Priority ready-queue task scheduler, top level.
// Depends on prq_pkg, prq_ctrl and prq_datapath.
//
// Usage:
//   A command transfers on a rising edge where start is high and busy is low.
//   cmd carries opcode, priority_req and delay_count. Exactly one result
//   follows per command: result_valid is high for one cycle with dispatch,
//   next_task, switch_count and status on result.
//   Steps: a command that does not schedule goes decode, result;
//   create/start/interrupt exit that schedule go decode, schedule, result;
//   a delay whose task is not ready goes decode (remove), delay, result;
//   a delay goes decode (remove), delay (park), schedule, result. busy
//   stays high until the controller returns to idle; a new command may
//   transfer in the cycle the result is shown, as the controller takes
//   one command at a time through its steps over the shared lists.
//   Ready and delayed lists are rows of shift cells kept sorted by priority.
//   Reset (rst, synchronous) empties both lists, the task table, interrupt
//   depth, started flag and switch count; no clearing pass is needed.
//   The receiver cannot stall: each result is shown for one cycle only.
module priority_ready_queue_scheduler import prq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    result_valid,
  output result_t result
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  prq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .ctl(ctl), .busy(busy)
  );

  prq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd_in(cmd), .ctl(ctl), .stat(stat),
    .result_valid(result_valid), .result(result)
  );

endmodule
